// ===== design/cobd_pkg.sv =====
// Shared types and constants for the camera object block deframer.
// Holds the result record, the sync and selector words and the result kinds.
// No dependencies.
package cobd_pkg;

    localparam int WORD_W = 16;
    localparam int CNT_W  = 5;
    localparam int SUM_W  = WORD_W + 3;

    localparam logic [1:0] KIND_NORMAL = 2'd0;
    localparam logic [1:0] KIND_CC     = 2'd1;
    localparam logic [1:0] KIND_FRAME  = 2'd2;

    // Three older bytes of the sync pattern and the byte that completes it.
    localparam logic [23:0] SYNC_WINDOW = 24'h000055;
    localparam logic [7:0]  SYNC_LAST   = 8'hAA;

    localparam logic [WORD_W-1:0] SEL_NORMAL = 16'hAA55;
    localparam logic [WORD_W-1:0] SEL_CC     = 16'hAA56;
    localparam logic [WORD_W-1:0] SEL_ZERO   = 16'h0000;

    // Index of the last byte of each block kind.
    localparam logic [3:0] LAST_NORMAL = 4'd11;
    localparam logic [3:0] LAST_CC     = 4'd13;

    typedef struct packed {
        logic              valid;
        logic [1:0]        kind;
        logic [WORD_W-1:0] signature;
        logic [WORD_W-1:0] pos_x;
        logic [WORD_W-1:0] pos_y;
        logic [WORD_W-1:0] obj_width;
        logic [WORD_W-1:0] obj_height;
        logic [WORD_W-1:0] obj_angle;
        logic [CNT_W-1:0]  normal_count;
        logic [CNT_W-1:0]  cc_count;
        logic              overflow;
    } result_t;

endpackage

// ===== design/cobd_in_reg.sv =====
// Input register of the deframer: holds one received byte until the parser
// takes it. Depends on nothing but the clock and reset.
module cobd_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

// ===== design/cobd_parser.sv =====
// Parse state of the deframer: sync hunting, selector words, block words,
// checksum test and frame tallies. Uses cobd_pkg.
module cobd_parser #(
    parameter int MAX_OBJECTS = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        cur_byte,
    output cobd_pkg::result_t res
);
    import cobd_pkg::*;

    localparam int TALLY_W = $clog2(MAX_OBJECTS + 1);

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_SELECT = 3'd1;
    localparam logic [2:0] PH_NORMAL = 3'd2;
    localparam logic [2:0] PH_CC     = 3'd3;
    localparam logic [2:0] PH_ZERO   = 3'd4;

    logic [23:0]        window_reg, window_next;
    logic [2:0]         phase_reg, phase_next;
    logic [3:0]         idx_reg, idx_next;
    logic [7:0]         hold_reg, hold_next;
    logic [TALLY_W-1:0] normal_reg, normal_next;
    logic [TALLY_W-1:0] cc_reg, cc_next;
    logic               lost_reg, lost_next;

    logic [WORD_W-1:0]  words [7];
    logic               word_we;
    logic [2:0]         word_addr;

    logic [WORD_W-1:0]  cur_word;
    logic [3:0]         last_idx;
    logic [3:0]         blk_idx;
    logic               is_cc;
    logic [SUM_W-1:0]   sum;
    logic [TALLY_W+CNT_W-1:0] normal_ext;
    logic [TALLY_W+CNT_W-1:0] cc_ext;

    assign cur_word   = {cur_byte, hold_reg};
    assign is_cc      = (phase_reg == PH_CC);
    assign last_idx   = is_cc ? LAST_CC : LAST_NORMAL;
    assign blk_idx    = (idx_reg > last_idx) ? last_idx : idx_reg;
    assign normal_ext = (TALLY_W + CNT_W)'(normal_reg);
    assign cc_ext     = (TALLY_W + CNT_W)'(cc_reg);

    // The checksum covers the stored words after the checksum word and the word that completes the block.
    assign sum = SUM_W'(words[1]) + SUM_W'(words[2]) + SUM_W'(words[3])
               + SUM_W'(words[4]) + (is_cc ? SUM_W'(words[5]) : '0)
               + SUM_W'(cur_word);

    always_comb
    begin
        window_next = window_reg;
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        hold_next   = hold_reg;
        normal_next = normal_reg;
        cc_next     = cc_reg;
        lost_next   = lost_reg;
        word_we     = 1'b0;
        word_addr   = blk_idx[3:1];
        res         = '0;

        case (phase_reg)
            PH_HUNT:
            begin
                if (idx_reg < 4'd3)
                begin
                    window_next = {window_reg[15:0], cur_byte};
                    idx_next    = idx_reg + 4'd1;
                end
                else if (window_reg == SYNC_WINDOW && cur_byte == SYNC_LAST)
                begin
                    phase_next  = PH_SELECT;
                    idx_next    = '0;
                    window_next = '0;
                end
                else
                begin
                    window_next = {window_reg[15:0], cur_byte};
                end
            end
            PH_SELECT:
            begin
                if (!idx_reg[0])
                begin
                    hold_next = cur_byte;
                    idx_next  = 4'd1;
                end
                else
                begin
                    idx_next = '0;
                    if (cur_word == SEL_NORMAL)
                    begin
                        phase_next = PH_NORMAL;
                    end
                    else if (cur_word == SEL_CC)
                    begin
                        phase_next = PH_CC;
                    end
                    else if (cur_word == SEL_ZERO)
                    begin
                        phase_next = PH_ZERO;
                    end
                    else
                    begin
                        phase_next  = PH_HUNT;
                        window_next = '0;
                    end
                end
            end
            PH_NORMAL, PH_CC:
            begin
                if (!blk_idx[0])
                begin
                    hold_next = cur_byte;
                end
                else
                begin
                    word_we = 1'b1;
                end
                if (blk_idx < last_idx)
                begin
                    idx_next = blk_idx + 4'd1;
                end
                else
                begin
                    idx_next   = '0;
                    phase_next = PH_SELECT;
                    if (sum == SUM_W'(words[0]))
                    begin
                        if (is_cc)
                        begin
                            if (cc_reg < TALLY_W'(MAX_OBJECTS))
                            begin
                                cc_next = cc_reg + TALLY_W'(1);
                            end
                            else
                            begin
                                lost_next = 1'b1;
                            end
                        end
                        else
                        begin
                            if (normal_reg < TALLY_W'(MAX_OBJECTS))
                            begin
                                normal_next = normal_reg + TALLY_W'(1);
                            end
                            else
                            begin
                                lost_next = 1'b1;
                            end
                        end
                        res.valid      = 1'b1;
                        res.kind       = is_cc ? KIND_CC : KIND_NORMAL;
                        res.signature  = words[1];
                        res.pos_x      = words[2];
                        res.pos_y      = words[3];
                        res.obj_width  = words[4];
                        res.obj_height = is_cc ? words[5] : cur_word;
                        res.obj_angle  = is_cc ? cur_word : '0;
                    end
                end
            end
            PH_ZERO:
            begin
                if (!idx_reg[0])
                begin
                    hold_next = cur_byte;
                    idx_next  = 4'd1;
                end
                else
                begin
                    idx_next = '0;
                    if (cur_word != SEL_NORMAL)
                    begin
                        phase_next  = PH_HUNT;
                        window_next = '0;
                    end
                    else
                    begin
                        phase_next       = PH_SELECT;
                        res.valid        = 1'b1;
                        res.kind         = KIND_FRAME;
                        res.normal_count = normal_ext[CNT_W-1:0];
                        res.cc_count     = cc_ext[CNT_W-1:0];
                        res.overflow     = lost_reg;
                        normal_next      = '0;
                        cc_next          = '0;
                        lost_next        = 1'b0;
                    end
                end
            end
            default:
            begin
                phase_next  = PH_HUNT;
                idx_next    = '0;
                window_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            phase_reg  <= PH_HUNT;
            idx_reg    <= '0;
            hold_reg   <= '0;
            normal_reg <= '0;
            cc_reg     <= '0;
            lost_reg   <= 1'b0;
        end
        else if (step)
        begin
            window_reg <= window_next;
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            hold_reg   <= hold_next;
            normal_reg <= normal_next;
            cc_reg     <= cc_next;
            lost_reg   <= lost_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && word_we)
        begin
            words[word_addr] <= cur_word;
        end
    end

endmodule

// ===== design/cobd_out_reg.sv =====
// Result register of the deframer: holds one result item until the receiver
// takes it. Uses cobd_pkg for the result record.
module cobd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  cobd_pkg::result_t load_res,
    input  logic              out_ready,
    output logic              out_valid,
    output cobd_pkg::result_t held_res
);
    import cobd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_valid = valid_reg;
    assign held_res  = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

endmodule

// ===== design/camera_object_block_deframer_unit.sv =====
// Camera object block deframer: top level.
// Instantiates cobd_in_reg, cobd_parser and cobd_out_reg; uses cobd_pkg.
//
// The input channel (in_valid, in_ready, rx_byte) carries one received serial
// byte per item. The output channel (out_valid, out_ready and the result
// fields) carries one item per valid normal block, valid color-code block or
// frame report; most bytes cause no result item.
// A byte is taken into the input register and parsed from there.
// If it completes a block or frame, its result is loaded into the output
// register as the byte advances, which raises out_valid; the result is then
// held there until the receiver takes it.
// One byte per cycle is accepted for as long as the output side keeps up; the
// whole parse step is one pass of logic from the input register to the result
// register.
// When the receiver stalls with a result waiting, bytes that cause no result
// keep flowing; a byte that completes a result waits in the input register,
// and in_ready falls until the output register is free.
// Reset leaves the parser hunting for the sync pattern with all frame counts
// and the overflow flag cleared, and both registers empty.
module camera_object_block_deframer_unit #(
    parameter int MAX_OBJECTS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] signature,
    output logic [15:0] pos_x,
    output logic [15:0] pos_y,
    output logic [15:0] obj_width,
    output logic [15:0] obj_height,
    output logic [15:0] obj_angle,
    output logic [4:0]  normal_count,
    output logic [4:0]  cc_count,
    output logic        overflow
);
    import cobd_pkg::*;

    logic    held_valid;
    logic [7:0] held_byte;
    logic    advance;
    result_t parse_res;
    result_t out_res;

    // A byte moves on unless it makes a result while the output is still full.
    assign advance = held_valid && (!parse_res.valid || !out_valid || out_ready);

    cobd_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    cobd_parser #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .cur_byte (held_byte),
        .res      (parse_res)
    );

    cobd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && parse_res.valid),
        .load_res  (parse_res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .held_res  (out_res)
    );

    assign kind         = out_res.kind;
    assign signature    = out_res.signature;
    assign pos_x        = out_res.pos_x;
    assign pos_y        = out_res.pos_y;
    assign obj_width    = out_res.obj_width;
    assign obj_height   = out_res.obj_height;
    assign obj_angle    = out_res.obj_angle;
    assign normal_count = out_res.normal_count;
    assign cc_count     = out_res.cc_count;
    assign overflow     = out_res.overflow;

endmodule
